FILE: rtl/core/jdc_pkg.sv
// ----------------------------------------------------------------------------
// Julian day converter package
// Field widths, pipeline depth, opcodes and the month span table shared by
// the converter datapaths.
// ----------------------------------------------------------------------------
`default_nettype none

package jdc_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int JD_W    = 22;
   localparam int WDAY_W  = 3;

   // Stages before the output register; the output register is the last one.
   localparam int CALC_STAGES = 6;
   localparam int NUM_STAGES  = CALC_STAGES + 1;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   typedef enum logic {
      OP_DATE_TO_JD = 1'b0,
      OP_JD_TO_DATE = 1'b1
   } opcode_type;

   // Month term of the day count for month index k, that is floor(30.6001 * k).
   function automatic logic [8:0] month_span(input logic [4:0] k);
      logic [8:0] span;
      case (k)
         5'd0:    span = 9'd0;
         5'd1:    span = 9'd30;
         5'd2:    span = 9'd61;
         5'd3:    span = 9'd91;
         5'd4:    span = 9'd122;
         5'd5:    span = 9'd153;
         5'd6:    span = 9'd183;
         5'd7:    span = 9'd214;
         5'd8:    span = 9'd244;
         5'd9:    span = 9'd275;
         5'd10:   span = 9'd306;
         5'd11:   span = 9'd336;
         5'd12:   span = 9'd367;
         5'd13:   span = 9'd397;
         5'd14:   span = 9'd428;
         5'd15:   span = 9'd459;
         5'd16:   span = 9'd489;
         default: span = 9'd0;
      endcase
      return span;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/jdc_weekday.sv
// ----------------------------------------------------------------------------
// Julian day converter weekday unit
// Two stages that reduce a day number modulo seven by summing octal digits,
// giving 0 for Sunday through 6 for Saturday.
// ----------------------------------------------------------------------------
`default_nettype none

module jdc_weekday (
   input  wire logic                           clock,
   input  wire logic [1:0]                     stage_en,
   input  wire logic [jdc_pkg::JD_W-1:0]       day_num,
   output logic      [jdc_pkg::WDAY_W-1:0]     weekday
);

   localparam int DIGITS = jdc_pkg::JD_W / 3;

   logic [5:0] sum_in;
   logic [5:0] sum_ff;
   logic [3:0] fold;
   logic [2:0] wday_in;
   logic [2:0] wday_ff;

   // Eight is one modulo seven, so octal digits add up to the same residue.
   always_comb begin
      sum_in = 6'd1 + {5'd0, day_num[jdc_pkg::JD_W-1]};
      for (int i = 0; i < DIGITS; i++) begin
         sum_in = sum_in + {3'd0, day_num[3*i +: 3]};
      end
   end

   always_comb begin
      fold    = {1'b0, sum_ff[5:3]} + {1'b0, sum_ff[2:0]};
      wday_in = (fold >= 4'd7) ? 3'(fold - 4'd7) : fold[2:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         sum_ff <= sum_in;
      end
      if (stage_en[1]) begin
         wday_ff <= wday_in;
      end
   end

   assign weekday = wday_ff;

endmodule

`default_nettype wire

FILE: rtl/core/jdc_date_path.sv
// ----------------------------------------------------------------------------
// Julian day converter date to day number path
// Adjusts the year and month, forms the year and month terms with the
// Gregorian correction, adds them and saturates to the day number range.
// ----------------------------------------------------------------------------
`default_nettype none

module jdc_date_path (
   input  wire logic                                clock,
   input  wire logic [jdc_pkg::CALC_STAGES-1:0]     stage_en,
   input  wire logic [jdc_pkg::YEAR_W-1:0]          year,
   input  wire logic [jdc_pkg::MONTH_W-1:0]         month,
   input  wire logic [jdc_pkg::DAY_W-1:0]           day,
   output logic      [jdc_pkg::JD_W-1:0]            jd_mid,
   output logic      [jdc_pkg::JD_W-1:0]            jd_last
);

   localparam logic [13:0] GREG_YEAR  = 14'd1582;
   localparam logic [3:0]  GREG_MONTH = 4'd10;
   localparam logic [4:0]  GREG_DAY   = 5'd15;
   localparam logic [24:0] JD_BASE    = 25'd1720995;

   // Stage 1: astronomical year and March based month.
   logic        neg;
   logic        early;
   logic [14:0] y_wide;
   logic [13:0] y1_in;
   logic [3:0]  m1_in;
   logic        g1_in;
   logic [13:0] y1_ff;
   logic [3:0]  m1_ff;
   logic [4:0]  d1_ff;
   logic        g1_ff;

   always_comb begin
      neg    = year[13];
      early  = (month <= 4'd2);
      y_wide = {year[13], year} + {14'd0, neg} - {14'd0, early};
      y1_in  = y_wide[13:0];
      m1_in  = early ? (month + 4'd12) : month;
      g1_in  = ($signed(y1_in) > $signed(GREG_YEAR)) ||
               ((y1_in == GREG_YEAR) &&
                ((m1_in > GREG_MONTH) || ((m1_in == GREG_MONTH) && (day >= GREG_DAY))));
   end

   // Stage 2: year term, century and month term.
   logic signed [25:0] a_prod;
   logic signed [25:0] a_quart;
   logic [25:0]        cent_prod;
   logic [23:0]        a2_in;
   logic [6:0]         c2_in;
   logic [8:0]         b2_in;
   logic [23:0]        a2_ff;
   logic [6:0]         c2_ff;
   logic [8:0]         b2_ff;
   logic [4:0]         d2_ff;
   logic               g2_ff;

   always_comb begin
      a_prod    = $signed({{12{y1_ff[13]}}, y1_ff}) * $signed(26'd1461);
      a_quart   = a_prod >>> 2;
      a2_in     = a_quart[23:0];
      // Division by 100 through a reciprocal; exact for years below 8192.
      cent_prod = {13'd0, y1_ff[12:0]} * 26'd5243;
      c2_in     = cent_prod[25:19];
      b2_in     = jdc_pkg::month_span({1'b0, m1_ff} + 5'd1);
   end

   // Stage 3: sum of all terms.
   logic [7:0]  corr;
   logic [24:0] s3_in;
   logic [24:0] s3_ff;

   always_comb begin
      corr  = g2_ff ? (8'd2 - {1'b0, c2_ff} + {3'd0, c2_ff[6:2]}) : 8'd0;
      s3_in = {a2_ff[23], a2_ff} + {16'd0, b2_ff} + {20'd0, d2_ff} + JD_BASE +
              {{17{corr[7]}}, corr};
   end

   // Stage 4: saturation, then the result is carried along.
   logic [21:0] r4_in;
   logic [21:0] r4_ff;
   logic [21:0] r5_ff;
   logic [21:0] r6_ff;

   always_comb begin
      if (s3_ff[24]) begin
         r4_in = '0;
      end else if (s3_ff[23:22] != 2'b00) begin
         r4_in = '1;
      end else begin
         r4_in = s3_ff[21:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         y1_ff <= y1_in;
         m1_ff <= m1_in;
         d1_ff <= day;
         g1_ff <= g1_in;
      end
      if (stage_en[1]) begin
         a2_ff <= a2_in;
         c2_ff <= c2_in;
         b2_ff <= b2_in;
         d2_ff <= d1_ff;
         g2_ff <= g1_ff;
      end
      if (stage_en[2]) begin
         s3_ff <= s3_in;
      end
      if (stage_en[3]) begin
         r4_ff <= r4_in;
      end
      if (stage_en[4]) begin
         r5_ff <= r4_ff;
      end
      if (stage_en[5]) begin
         r6_ff <= r5_ff;
      end
   end

   assign jd_mid  = r4_ff;
   assign jd_last = r6_ff;

endmodule

`default_nettype wire

FILE: rtl/core/jdc_jd_path.sv
// ----------------------------------------------------------------------------
// Julian day converter day number to date path
// Gregorian correction, year count and month count, each division done as a
// multiplication by a constant reciprocal in a stage of its own.
// ----------------------------------------------------------------------------
`default_nettype none

module jdc_jd_path (
   input  wire logic                                clock,
   input  wire logic [jdc_pkg::CALC_STAGES-1:0]     stage_en,
   input  wire logic [jdc_pkg::JD_W-1:0]            julian_day,
   output logic      [jdc_pkg::JD_W-1:0]            jd_mid,
   output logic      [jdc_pkg::YEAR_W-1:0]          year_next,
   output logic      [jdc_pkg::MONTH_W-1:0]         month_next,
   output logic      [jdc_pkg::DAY_W-1:0]           day_next
);

   localparam logic [21:0] GREG_START_JD = 22'd2299161;
   localparam logic [23:0] CENT_OFFSET   = 24'd7468865;
   localparam logic [22:0] DAY_OFFSET    = 23'd1524;
   localparam logic [26:0] YEAR_OFFSET   = 27'd2442;
   localparam logic [14:0] EPOCH_YEAR    = 15'd4716;
   localparam logic [13:0] EPOCH_C       = 14'd4716;

   localparam logic [63:0] RECIP_A_WIDE = ((64'd1 << 42) + 64'd146096) / 64'd146097;
   localparam logic [63:0] RECIP_B_WIDE = ((64'd1 << 40) + 64'd7304) / 64'd7305;
   localparam logic [63:0] RECIP_C_WIDE = ((64'd10000 << 28) + 64'd306000) / 64'd306001;
   localparam logic [24:0] RECIP_A = RECIP_A_WIDE[24:0];
   localparam logic [27:0] RECIP_B = RECIP_B_WIDE[27:0];
   localparam logic [23:0] RECIP_C = RECIP_C_WIDE[23:0];

   // Stage 1: numerator of the century count.
   logic [23:0] n1_in;
   logic        g1_in;
   logic [21:0] z1_ff;
   logic [23:0] n1_ff;
   logic        g1_ff;

   always_comb begin
      n1_in = {julian_day, 2'b00} - CENT_OFFSET;
      g1_in = (julian_day >= GREG_START_JD);
   end

   // Stage 2: century count.
   logic [48:0] p1;
   logic [5:0]  al2_in;
   logic [21:0] z2_ff;
   logic [5:0]  al2_ff;
   logic        g2_ff;

   always_comb begin
      p1     = {25'd0, n1_ff} * {24'd0, RECIP_A};
      al2_in = p1[47:42];
   end

   // Stage 3: corrected day count and numerator of the year count.
   logic [6:0]  adj;
   logic [22:0] a3;
   logic [22:0] b3_in;
   logic [26:0] n3_in;
   logic [21:0] z3_ff;
   logic [22:0] b3_ff;
   logic [26:0] n3_ff;

   always_comb begin
      adj   = g2_ff ? (7'd1 + {1'b0, al2_ff} - {3'd0, al2_ff[5:2]}) : 7'd0;
      a3    = {1'b0, z2_ff} + {16'd0, adj};
      b3_in = a3 + DAY_OFFSET;
      n3_in = {b3_in, 4'b0000} + {2'b00, b3_in, 2'b00} - YEAR_OFFSET;
   end

   // Stage 4: year count.
   logic [54:0] p2;
   logic [13:0] c4_in;
   logic [21:0] z4_ff;
   logic [22:0] b4_ff;
   logic [13:0] c4_ff;

   always_comb begin
      p2    = {28'd0, n3_ff} * {27'd0, RECIP_B};
      c4_in = p2[53:40];
   end

   // Stage 5: days into the March based year, always below 512.
   logic [24:0] d_prod;
   logic [22:0] x_full;
   logic [8:0]  x5_in;
   logic [8:0]  x5_ff;
   logic [13:0] c5_ff;

   always_comb begin
      d_prod = {11'd0, c4_ff} * 25'd1461;
      x_full = b4_ff - d_prod[24:2];
      x5_in  = x_full[8:0];
   end

   // Stage 6: month count.
   logic [32:0] p3;
   logic [3:0]  e6_in;
   logic [8:0]  x6_ff;
   logic [13:0] c6_ff;
   logic [3:0]  e6_ff;

   always_comb begin
      p3    = {24'd0, x5_ff} * {9'd0, RECIP_C};
      e6_in = p3[31:28];
   end

   // Final date fields, registered by the output stage.
   logic [8:0]  day_diff;
   logic [3:0]  mo;
   logic [14:0] c15;
   logic [14:0] yr;

   always_comb begin
      day_diff = x6_ff - jdc_pkg::month_span({1'b0, e6_ff});
      mo       = (e6_ff <= 4'd13) ? (e6_ff - 4'd1) : (e6_ff - 4'd13);
      c15      = {1'b0, c6_ff};
      // There is no year zero, so counts that land on or before it step back by one.
      if (mo > 4'd2) begin
         yr = (c6_ff <= EPOCH_C) ? (c15 - EPOCH_YEAR - 15'd1) : (c15 - EPOCH_YEAR);
      end else begin
         yr = (c6_ff <= EPOCH_C - 14'd1) ? (c15 - EPOCH_YEAR) : (c15 - EPOCH_YEAR + 15'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         z1_ff <= julian_day;
         n1_ff <= n1_in;
         g1_ff <= g1_in;
      end
      if (stage_en[1]) begin
         z2_ff  <= z1_ff;
         al2_ff <= al2_in;
         g2_ff  <= g1_ff;
      end
      if (stage_en[2]) begin
         z3_ff <= z2_ff;
         b3_ff <= b3_in;
         n3_ff <= n3_in;
      end
      if (stage_en[3]) begin
         z4_ff <= z3_ff;
         b4_ff <= b3_ff;
         c4_ff <= c4_in;
      end
      if (stage_en[4]) begin
         x5_ff <= x5_in;
         c5_ff <= c4_ff;
      end
      if (stage_en[5]) begin
         x6_ff <= x5_ff;
         c6_ff <= c5_ff;
         e6_ff <= e6_in;
      end
   end

   assign jd_mid     = z4_ff;
   assign year_next  = yr[13:0];
   assign month_next = mo;
   assign day_next   = day_diff[4:0];

endmodule

`default_nettype wire

FILE: rtl/core/julian_day_converter.sv
// ----------------------------------------------------------------------------
// Julian day converter
// Converts a calendar date to a Julian day number or a day number to a date,
// with the weekday in both cases, selected per word, in a seven stage pipeline.
// ----------------------------------------------------------------------------
//  channel  direction  tdata fields (low bit first)                 tuser
//  req_     in         year 14, month 4, day 5, julian_day 22, pad  opcode
//  rsp_     out        out_julian_day 22, out_year 14, out_month 4,  -
//                      out_day 5, weekday 3
//
//  One word is accepted per cycle while req_tready is high; each result leaves
//  after passing through every stage of the pipeline.
//  Reset clears only the stage valid bits; the pipeline is empty afterwards.
//  A stalled result stage holds its word while earlier stages keep filling
//  empty slots, so req_tready falls only when every stage is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module julian_day_converter (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // year [13:0], month [17:14], day [22:18], julian_day [44:23], zero [47:45]
   input  wire logic [jdc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // opcode [0]
   input  wire logic                               req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // out_julian_day [21:0], out_year [35:22], out_month [39:36], out_day [44:40],
   // weekday [47:45]
   output logic      [jdc_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int LAST = jdc_pkg::NUM_STAGES - 1;

   logic [jdc_pkg::NUM_STAGES-1:0]  take;
   logic [jdc_pkg::NUM_STAGES-1:0]  valid_in;
   logic [jdc_pkg::NUM_STAGES-1:0]  valid_ff;
   jdc_pkg::opcode_type             op_ff [jdc_pkg::CALC_STAGES];

   logic [jdc_pkg::YEAR_W-1:0]      req_year;
   logic [jdc_pkg::MONTH_W-1:0]     req_month;
   logic [jdc_pkg::DAY_W-1:0]       req_day;
   logic [jdc_pkg::JD_W-1:0]        req_jd;

   logic [jdc_pkg::JD_W-1:0]        date_jd_mid;
   logic [jdc_pkg::JD_W-1:0]        date_jd_last;
   logic [jdc_pkg::JD_W-1:0]        jd_mid;
   logic [jdc_pkg::YEAR_W-1:0]      jd_year;
   logic [jdc_pkg::MONTH_W-1:0]     jd_month;
   logic [jdc_pkg::DAY_W-1:0]       jd_day;
   logic [jdc_pkg::JD_W-1:0]        wday_src;
   logic [jdc_pkg::WDAY_W-1:0]      wday;

   logic [jdc_pkg::RSP_DATA_W-1:0]  rsp_in;
   logic [jdc_pkg::RSP_DATA_W-1:0]  rsp_ff;

   assign req_year  = req_tdata[13:0];
   assign req_month = req_tdata[17:14];
   assign req_day   = req_tdata[22:18];
   assign req_jd    = req_tdata[44:23];

   // A stage can load when it is empty or its word moves on in the same cycle.
   always_comb begin
      take[LAST] = !valid_ff[LAST] || rsp_tready;
      for (int i = LAST - 1; i >= 0; i--) begin
         take[i] = !valid_ff[i] || take[i+1];
      end
      valid_in = {valid_ff[LAST-1:0], req_tvalid};
   end

   assign req_tready = take[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < jdc_pkg::NUM_STAGES; i++) begin
            if (take[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take[0]) begin
         op_ff[0] <= jdc_pkg::opcode_type'(req_tuser);
      end
      for (int i = 1; i < jdc_pkg::CALC_STAGES; i++) begin
         if (take[i]) begin
            op_ff[i] <= op_ff[i-1];
         end
      end
   end

   jdc_date_path u_date_path (
      .clock    (clock),
      .stage_en (take[jdc_pkg::CALC_STAGES-1:0]),
      .year     (req_year),
      .month    (req_month),
      .day      (req_day),
      .jd_mid   (date_jd_mid),
      .jd_last  (date_jd_last)
   );

   jdc_jd_path u_jd_path (
      .clock      (clock),
      .stage_en   (take[jdc_pkg::CALC_STAGES-1:0]),
      .julian_day (req_jd),
      .jd_mid     (jd_mid),
      .year_next  (jd_year),
      .month_next (jd_month),
      .day_next   (jd_day)
   );

   assign wday_src = (op_ff[3] == jdc_pkg::OP_JD_TO_DATE) ? jd_mid : date_jd_mid;

   jdc_weekday u_weekday (
      .clock    (clock),
      .stage_en (take[5:4]),
      .day_num  (wday_src),
      .weekday  (wday)
   );

   always_comb begin
      if (op_ff[jdc_pkg::CALC_STAGES-1] == jdc_pkg::OP_JD_TO_DATE) begin
         rsp_in = {wday, jd_day, jd_month, jd_year, {jdc_pkg::JD_W{1'b0}}};
      end else begin
         rsp_in = {wday, {jdc_pkg::DAY_W{1'b0}}, {jdc_pkg::MONTH_W{1'b0}},
                   {jdc_pkg::YEAR_W{1'b0}}, date_jd_last};
      end
   end

   always_ff @(posedge clock) begin
      if (take[LAST]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = valid_ff[LAST];
   assign rsp_tdata  = rsp_ff;

endmodule

`default_nettype wire

FILE: sim/tb_julian_day_converter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Julian day converter testbench
// Sends dates and day numbers through the converter with random gaps on
// both channels and compares every result word, field by field, with a
// behavioral model of the conversion kept in this file.
// ----------------------------------------------------------------------------

module tb_julian_day_converter;

   localparam int YEAR_W  = jdc_pkg::YEAR_W;
   localparam int MONTH_W = jdc_pkg::MONTH_W;
   localparam int DAY_W   = jdc_pkg::DAY_W;
   localparam int JD_W    = jdc_pkg::JD_W;
   localparam int WDAY_W  = jdc_pkg::WDAY_W;

   localparam longint REFORM_YMD    = 15821015;
   localparam longint REFORM_DAY    = 2299161;
   localparam longint EPOCH_OFFSET  = 1720995;
   localparam longint DAY_LIMIT     = 4194303;
   localparam longint LAST_VALID_JD = 3547272;

   typedef struct packed {
      logic [2:0]         pad;
      logic [JD_W-1:0]    jd;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_request_type;

   typedef struct packed {
      logic [WDAY_W-1:0]  weekday;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic [JD_W-1:0]    jd;
   } date_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [jdc_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           req_tuser = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [jdc_pkg::RSP_DATA_W-1:0] rsp_tdata;

   date_result_type pending_results[$];
   int           error_count    = 0;
   int           words_sent     = 0;
   int           dates_sent     = 0;
   int           day_nums_sent  = 0;
   int           results_seen   = 0;
   int           hold_off_cycles = 0;
   int           longest_hold   = 0;
   int           rsp_stall_left = 0;
   bit           steady_stream  = 1'b0;

   julian_day_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
   endfunction

   function automatic logic [WDAY_W-1:0] weekday_of(longint jd);
      longint w;
      w = ((jd % 7) + 1) % 7;
      return WDAY_W'(w);
   endfunction

   function automatic date_result_type convert_word(jdc_pkg::opcode_type op,
                                                    date_request_type w);
      date_result_type r;
      longint y, m, dd, cent, corr, jd;
      longint z, alpha, a, b, c, d, e, mo, yr;
      r = '0;
      if (op == jdc_pkg::OP_DATE_TO_JD) begin
         y    = longint'($signed(w.year));
         m    = w.month;
         dd   = w.day;
         corr = 0;
         if (y < 0) y++;
         if (m <= 2) begin
            y--;
            m += 12;
         end
         if (y * 10000 + m * 100 + dd >= REFORM_YMD) begin
            cent = y / 100;
            corr = 2 - cent + cent / 4;
         end
         jd = floor_div(1461 * y, 4) + floor_div(306001 * (m + 1), 10000) + dd
              + EPOCH_OFFSET + corr;
         if (jd < 0) jd = 0;
         if (jd > DAY_LIMIT) jd = DAY_LIMIT;
         r.jd      = JD_W'(jd);
         r.weekday = weekday_of(jd);
      end else begin
         z = w.jd;
         if (z < REFORM_DAY) begin
            a = z;
         end else begin
            alpha = floor_div(4 * z - 7468865, 146097);
            a     = z + 1 + alpha - floor_div(alpha, 4);
         end
         b  = a + 1524;
         c  = floor_div(20 * b - 2442, 7305);
         d  = floor_div(1461 * c, 4);
         e  = floor_div(10000 * (b - d), 306001);
         mo = (e <= 13) ? e - 1 : e - 13;
         yr = (mo > 2) ? c - 4716 : c - 4715;
         if (yr <= 0) yr -= 1;
         r.day     = DAY_W'(b - d - floor_div(306001 * e, 10000));
         r.month   = MONTH_W'(mo);
         r.year    = YEAR_W'(yr);
         r.weekday = weekday_of(z);
      end
      return r;
   endfunction

   function automatic int idle_gap();
      int roll;
      if (steady_stream) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // Offers one word and returns at the edge that accepts it.
   task automatic send_word(input jdc_pkg::opcode_type op, input date_request_type w);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(convert_word(op, w));
      words_sent++;
      if (op == jdc_pkg::OP_DATE_TO_JD) dates_sent++;
      else day_nums_sent++;
   endtask

   task automatic send_date(input int year, input int month, input int day);
      date_request_type w;
      w       = '0;
      w.year  = YEAR_W'(year);
      w.month = MONTH_W'(month);
      w.day   = DAY_W'(day);
      send_word(jdc_pkg::OP_DATE_TO_JD, w);
   endtask

   task automatic send_day_number(input int jd);
      date_request_type w;
      w    = '0;
      w.jd = JD_W'(jd);
      send_word(jdc_pkg::OP_JD_TO_DATE, w);
   endtask

   task automatic random_word(output jdc_pkg::opcode_type op, output date_request_type w);
      int roll;
      roll    = $urandom_range(0, 99);
      op      = jdc_pkg::opcode_type'($urandom_range(0, 1));
      w       = '0;
      w.year  = YEAR_W'($urandom_range(0, 9712) - 4713);
      w.month = MONTH_W'($urandom_range(1, 12));
      w.day   = DAY_W'($urandom_range(1, 31));
      w.jd    = JD_W'($urandom_range(0, LAST_VALID_JD));
      if (roll < 12) begin
         w.year  = YEAR_W'($urandom_range(0, 1) ? 1582 : $urandom_range(0, 2) - 1);
         w.month = MONTH_W'($urandom_range(9, 11));
         w.jd    = JD_W'(REFORM_DAY - 20 + $urandom_range(0, 40));
      end else if (roll < 30) begin
         w.year  = YEAR_W'($urandom);
         w.month = MONTH_W'($urandom);
         w.day   = DAY_W'($urandom);
         w.jd    = JD_W'($urandom);
      end
   endtask

   task automatic test_directed_dates();
      send_date(-4713, 1, 1);
      send_date(4999, 12, 31);
      send_date(-8192, 0, 0);
      send_date(8191, 15, 31);
      send_date(1582, 10, 4);
      send_date(1582, 10, 5);
      send_date(1582, 10, 15);
      send_date(-1, 3, 1);
      send_date(0, 3, 1);
      send_date(1, 1, 1);
      send_date(2000, 2, 29);
      send_date(1900, 2, 31);
      send_date(2024, 13, 0);
   endtask

   task automatic test_directed_day_numbers();
      send_day_number(0);
      send_day_number(1);
      send_day_number(1721423);
      send_day_number(1721424);
      send_day_number(2299160);
      send_day_number(2299161);
      send_day_number(2451545);
      send_day_number(3547272);
      send_day_number(4194303);
      send_day_number(2097152);
   endtask

   task automatic test_random_mix(input int count);
      jdc_pkg::opcode_type op;
      date_request_type    w;
      repeat (count) begin
         random_word(op, w);
         send_word(op, w);
      end
   endtask

   task automatic test_back_pressure();
      jdc_pkg::opcode_type op;
      date_request_type    w;
      steady_stream   = 1'b1;
      hold_off_cycles = 80;
      longest_hold    = 80;
      repeat (40) begin
         random_word(op, w);
         send_word(op, w);
      end
      steady_stream = 1'b0;
   endtask

   task automatic test_steady_stream();
      jdc_pkg::opcode_type op;
      date_request_type    w;
      steady_stream = 1'b1;
      repeat (80) begin
         random_word(op, w);
         send_word(op, w);
      end
      steady_stream = 1'b0;
   endtask

   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_off_cycles--;
      end else if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_tready     <= 1'b1;
         rsp_stall_left = idle_gap();
      end
   end

   always @(posedge clock) begin
      date_result_type got;
      date_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result word %h", rsp_tdata));
         end else begin
            want = pending_results.pop_front();
            if (got.jd !== want.jd)
               report_mismatch($sformatf("word %0d out_julian_day %0d, expected %0d",
                                         results_seen, got.jd, want.jd));
            if (got.year !== want.year)
               report_mismatch($sformatf("word %0d out_year %0d, expected %0d",
                                         results_seen, $signed(got.year),
                                         $signed(want.year)));
            if (got.month !== want.month)
               report_mismatch($sformatf("word %0d out_month %0d, expected %0d",
                                         results_seen, got.month, want.month));
            if (got.day !== want.day)
               report_mismatch($sformatf("word %0d out_day %0d, expected %0d",
                                         results_seen, got.day, want.day));
            if (got.weekday !== want.weekday)
               report_mismatch($sformatf("word %0d weekday %0d, expected %0d",
                                         results_seen, got.weekday, want.weekday));
         end
         results_seen++;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_dates();
      test_directed_day_numbers();
      test_random_mix(260);
      test_back_pressure();
      test_random_mix(260);
      test_steady_stream();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (jdc_pkg::NUM_STAGES + 8) @(posedge clock);
      $display("Converted %0d words: %0d dates and %0d day numbers, %0d results checked.",
               words_sent, dates_sent, day_nums_sent, results_seen);
      $display("Covered BC years, the calendar reform, saturation, nonsense dates and a %0d %s",
               longest_hold, "cycle output stall with the pipeline full.");
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d results outstanding.", pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
